[rtl/circular_deque_defines.svh]
// Assertion macros used by the deque top level.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CDQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deque check failed");

// Next-cycle implication, checked out of reset.
`define CDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

[rtl/cdq_pkg.sv]
package cdq_pkg;

  localparam int unsigned CdqDepthDefault = 128;
  localparam int unsigned CdqWordW        = 32;
  localparam int unsigned CdqActW         = 3;
  localparam int unsigned CdqCountW       = 8;

  // Word reported for front and back while the deque is empty (-1).
  localparam logic [CdqWordW-1:0] CdqEmptyWord = '1;

  // Action codes of an input transfer.
  localparam logic [CdqActW-1:0] ActNone      = 3'd0;
  localparam logic [CdqActW-1:0] ActPushFront = 3'd1;
  localparam logic [CdqActW-1:0] ActPushBack  = 3'd2;
  localparam logic [CdqActW-1:0] ActPopFront  = 3'd3;
  localparam logic [CdqActW-1:0] ActPopBack   = 3'd4;

  // Command broadcast to every cell of one chain.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT_IN,
    OP_SHIFT_OUT,
    OP_APPEND,
    OP_TRUNC
  } cdq_op_e;

  typedef struct packed {
    logic [CdqActW-1:0]          action;
    logic signed [CdqWordW-1:0]  value;
  } cdq_in_t;

  typedef struct packed {
    logic signed [CdqWordW-1:0]  front_value;
    logic signed [CdqWordW-1:0]  back_value;
    logic [CdqCountW-1:0]        count;
    logic                        is_empty;
    logic                        is_full;
    logic                        done_res;
  } cdq_out_t;

endpackage

[rtl/cdq_cell.sv]
module cdq_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cdq_pkg::cdq_op_e              op_i,
  input  logic [cdq_pkg::CdqWordW-1:0]  push_data_i,
  input  logic                          lo_valid_i,
  input  logic [cdq_pkg::CdqWordW-1:0]  lo_data_i,
  input  logic                          hi_valid_i,
  input  logic [cdq_pkg::CdqWordW-1:0]  hi_data_i,
  output logic                          valid_o,
  output logic [cdq_pkg::CdqWordW-1:0]  data_o
);
  import cdq_pkg::*;

  logic                valid_q, valid_d;
  logic [CdqWordW-1:0] data_q, data_d;

  // The lower neighbor sits toward the chain's open end, the upper one toward its tail.
  // An append lands the pushed word in the first empty cell past the occupied run.
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    unique case (op_i)
      OP_HOLD: begin
      end
      OP_SHIFT_IN: begin
        valid_d = lo_valid_i;
        data_d  = lo_data_i;
      end
      OP_SHIFT_OUT: begin
        valid_d = hi_valid_i;
        data_d  = hi_data_i;
      end
      OP_APPEND: begin
        if (!valid_q && lo_valid_i) begin
          valid_d = 1'b1;
          data_d  = push_data_i;
        end
      end
      OP_TRUNC: begin
        if (valid_q && !hi_valid_i) begin
          valid_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/cdq_chain.sv]
module cdq_chain #(
  parameter int unsigned DEPTH = cdq_pkg::CdqDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cdq_pkg::cdq_op_e              op_i,
  input  logic [cdq_pkg::CdqWordW-1:0]  push_data_i,
  output logic                          head_valid_o,
  output logic [cdq_pkg::CdqWordW-1:0]  head_data_o
);
  import cdq_pkg::*;

  logic                valid_w [DEPTH];
  logic [CdqWordW-1:0] data_w  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                lo_valid, hi_valid;
    logic [CdqWordW-1:0] lo_data, hi_data;

    // The open end sees a permanently valid neighbor carrying the pushed word.
    if (i == 0) begin : g_open
      assign lo_valid = 1'b1;
      assign lo_data  = push_data_i;
    end else begin : g_mid_lo
      assign lo_valid = valid_w[i-1];
      assign lo_data  = data_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign hi_valid = 1'b0;
      assign hi_data  = '0;
    end else begin : g_mid_hi
      assign hi_valid = valid_w[i+1];
      assign hi_data  = data_w[i+1];
    end

    cdq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op_i),
      .push_data_i (push_data_i),
      .lo_valid_i  (lo_valid),
      .lo_data_i   (lo_data),
      .hi_valid_i  (hi_valid),
      .hi_data_i   (hi_data),
      .valid_o     (valid_w[i]),
      .data_o      (data_w[i])
    );
  end

  assign head_valid_o = valid_w[0];
  assign head_data_o  = data_w[0];

endmodule

[rtl/circular_deque.sv]
// Channel   | Ports                            | Transfer rule
// ----------+----------------------------------+------------------------------------
// command   | start, busy, item_i              | rising edge with start high, busy low
// result    | result_valid_o, result_o         | one cycle strobe, always taken
//
// A command is taken in any cycle; busy stays low, so one transfer per clock is sustained.
// Its result appears on the cycle right after the command edge, registered in
// the single register stage of the cell chains and the element counter.
// Reset (rst_ni low, asynchronous) empties both chains and clears the counter at once.
// The receiver cannot stall; each result strobe lasts exactly one cycle.
module circular_deque #(
  parameter int unsigned DEPTH = cdq_pkg::CdqDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cdq_pkg::cdq_in_t  item_i,
  output logic              result_valid_o,
  output cdq_pkg::cdq_out_t result_o
);
  import cdq_pkg::*;
  `include "circular_deque_defines.svh"

  // The deque is kept as two rows of cells holding the same elements in
  // opposite order. In the front row cell 0 is the front element; in the back
  // row cell 0 is the rear element. A push at one end shifts that end's row
  // by one cell and appends the word at the far end of the other row, so
  // both ends are always visible in cell 0 without any wide read mux.
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic            accept;
  logic [CntW-1:0] count_q, count_d;
  logic            res_valid_q;
  logic            done_q, done_d;
  logic            empty, full;
  cdq_op_e         f_op, b_op;

  logic                f_head_valid, b_head_valid;
  logic [CdqWordW-1:0] f_head_data, b_head_data;
  logic [CdqWordW-1:0] push_word;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign empty     = (count_q == '0);
  assign full      = (count_q == CntW'(DEPTH));
  assign push_word = item_i.value;

  // Decode the command into one operation for each row. A push into a full
  // deque, a pop from an empty one and an unknown action leave both rows alone.
  always_comb begin
    f_op    = OP_HOLD;
    b_op    = OP_HOLD;
    count_d = count_q;
    done_d  = 1'b0;
    if (accept) begin
      unique case (item_i.action)
        ActNone: begin
          done_d = 1'b1;
        end
        ActPushFront: begin
          if (!full) begin
            f_op    = OP_SHIFT_IN;
            b_op    = OP_APPEND;
            count_d = count_q + CntW'(1);
            done_d  = 1'b1;
          end
        end
        ActPushBack: begin
          if (!full) begin
            f_op    = OP_APPEND;
            b_op    = OP_SHIFT_IN;
            count_d = count_q + CntW'(1);
            done_d  = 1'b1;
          end
        end
        ActPopFront: begin
          if (!empty) begin
            f_op    = OP_SHIFT_OUT;
            b_op    = OP_TRUNC;
            count_d = count_q - CntW'(1);
            done_d  = 1'b1;
          end
        end
        ActPopBack: begin
          if (!empty) begin
            f_op    = OP_TRUNC;
            b_op    = OP_SHIFT_OUT;
            count_d = count_q - CntW'(1);
            done_d  = 1'b1;
          end
        end
        default: begin
          done_d = 1'b0;
        end
      endcase
    end
  end

  cdq_chain #(
    .DEPTH (DEPTH)
  ) u_front_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (f_op),
    .push_data_i  (push_word),
    .head_valid_o (f_head_valid),
    .head_data_o  (f_head_data)
  );

  cdq_chain #(
    .DEPTH (DEPTH)
  ) u_back_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (b_op),
    .push_data_i  (push_word),
    .head_valid_o (b_head_valid),
    .head_data_o  (b_head_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= accept;
      done_q      <= done_d;
    end
  end

  // During the strobe cycle the rows and the counter already hold the state
  // after the command, so the result is read straight from them.
  assign result_valid_o        = res_valid_q;
  assign result_o.front_value  = empty ? CdqEmptyWord : f_head_data;
  assign result_o.back_value   = empty ? CdqEmptyWord : b_head_data;
  assign result_o.count        = CdqCountW'(count_q);
  assign result_o.is_empty     = empty;
  assign result_o.is_full      = full;
  assign result_o.done_res     = done_q;

  `CDQ_ASSERT_NOW(a_count_in_range, 1'b1, count_q <= CntW'(DEPTH))
  `CDQ_ASSERT_NOW(a_front_row_tracks_count, 1'b1, f_head_valid == !empty)
  `CDQ_ASSERT_NOW(a_back_row_tracks_count, 1'b1, b_head_valid == !empty)
  `CDQ_ASSERT_NEXT(a_strobe_follows_command, accept, res_valid_q)
  `CDQ_ASSERT_NEXT(a_no_pop_when_empty,
    accept && empty && (item_i.action == ActPopFront || item_i.action == ActPopBack),
    !done_q && empty)

endmodule
